/* rtl/core/fca_pkg.sv */
package fca_pkg;

  localparam int unsigned DEF_INPUT_BITS = 32;
  localparam int unsigned DEF_ANGLE_BITS = 32;

  localparam int unsigned STEPS    = 62;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned NORM_TOP = 60;
  localparam int unsigned Z_FRAC   = 62;
  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned BAND_W   = 31;

  localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(1);
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

  typedef enum logic [1:0] {
    KIND_GENERAL,
    KIND_Y_ZERO,
    KIND_X_ZERO
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  yneg;
    logic  xneg;
  } meta_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    meta_t             meta;
  } cordic_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] div_small(input logic [63:0] num, input logic [7:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {57'd0, den}) begin
        r    = r - {57'd0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-step) in q62 turns, series in q62 radians scaled by 1/(2 pi)
  function automatic logic [63:0] atan_turns(input int unsigned step);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [127:0] prod;
    int unsigned  k;
    int unsigned  e;
    if (step == 0) begin
      return 64'd1 << 59;
    end
    rad = '0;
    k   = 0;
    while (step * (2 * k + 1) <= 62) begin
      e    = step * (2 * k + 1);
      term = div_small(64'd1 << (62 - e), 8'(2 * k + 1));
      if (k[0]) begin
        rad = rad - term;
      end else begin
        rad = rad + term;
      end
      k = k + 1;
    end
    prod = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
    return prod[127:64];
  endfunction

endpackage

/* rtl/core/fca_front.sv */
module fca_front #(
  parameter int unsigned INPUT_BITS = fca_pkg::DEF_INPUT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [fca_pkg::BAND_W-1:0]  band_i,
  input  logic                        valid_i,
  input  logic [INPUT_BITS-1:0]       y_value_i,
  input  logic [INPUT_BITS-1:0]       x_value_i,
  output logic                        valid_o,
  output fca_pkg::cordic_t            data_o
);
  import fca_pkg::*;

  localparam int unsigned CW     = (INPUT_BITS > BAND_W) ? INPUT_BITS : BAND_W;
  localparam int unsigned CHUNK  = 8;
  localparam int unsigned NCHUNK = DATA_W / CHUNK;

  // stage 1: magnitudes
  logic                  v1_q;
  logic [INPUT_BITS-1:0] ay1_d, ax1_d, ay1_q, ax1_q;
  logic                  yneg1_q, xneg1_q;

  // stage 2: zero band and larger magnitude
  logic              v2_q;
  logic [DATA_W-1:0] ay2_q, ax2_q, m2_d, m2_q;
  meta_t             meta2_d, meta2_q;

  // stage 3: bit length per byte
  logic              v3_q;
  logic [DATA_W-1:0] ay3_q, ax3_q;
  meta_t             meta3_q;
  logic [3:0]        cbl_d [NCHUNK];
  logic [3:0]        cbl_q [NCHUNK];

  // stage 4: shift amount
  logic              v4_q;
  logic [DATA_W-1:0] ay4_q, ax4_q;
  meta_t             meta4_q;
  logic [6:0]        bl;
  logic              left4_d, left4_q;
  logic [5:0]        amt4_d, amt4_q;

  // stage 5: normalized vector
  logic              v5_q;
  cordic_t           out_d, out_q;

  assign ay1_d = y_value_i[INPUT_BITS-1] ? (~y_value_i + INPUT_BITS'(1)) : y_value_i;
  assign ax1_d = x_value_i[INPUT_BITS-1] ? (~x_value_i + INPUT_BITS'(1)) : x_value_i;

  always_comb begin
    meta2_d.yneg = yneg1_q;
    meta2_d.xneg = xneg1_q;
    // y is tested first so that the origin lands on zero
    if (CW'(ay1_q) < CW'(band_i)) begin
      meta2_d.kind = KIND_Y_ZERO;
    end else if (CW'(ax1_q) < CW'(band_i)) begin
      meta2_d.kind = KIND_X_ZERO;
    end else begin
      meta2_d.kind = KIND_GENERAL;
    end
    m2_d = (ax1_q > ay1_q) ? DATA_W'(ax1_q) : DATA_W'(ay1_q);
  end

  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      cbl_d[c] = '0;
      for (int b = 0; b < CHUNK; b++) begin
        if (m2_q[c*CHUNK+b]) begin
          cbl_d[c] = 4'(b + 1);
        end
      end
    end
  end

  always_comb begin
    bl = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (cbl_q[c] != '0) begin
        bl = 7'(c * CHUNK) + 7'(cbl_q[c]);
      end
    end
    // bring the leading one to bit NORM_TOP-1
    if (bl > 7'(NORM_TOP)) begin
      left4_d = 1'b0;
      amt4_d  = 6'(bl - 7'(NORM_TOP));
    end else if (bl != '0) begin
      left4_d = 1'b1;
      amt4_d  = 6'(7'(NORM_TOP) - bl);
    end else begin
      left4_d = 1'b1;
      amt4_d  = '0;
    end
  end

  always_comb begin
    out_d.meta = meta4_q;
    out_d.z    = '0;
    if (left4_q) begin
      out_d.x = ax4_q << amt4_q;
      out_d.y = ay4_q << amt4_q;
    end else begin
      out_d.x = ax4_q >> amt4_q;
      out_d.y = ay4_q >> amt4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ay1_q   <= ay1_d;
      ax1_q   <= ax1_d;
      yneg1_q <= y_value_i[INPUT_BITS-1];
      xneg1_q <= x_value_i[INPUT_BITS-1];

      ay2_q   <= DATA_W'(ay1_q);
      ax2_q   <= DATA_W'(ax1_q);
      m2_q    <= m2_d;
      meta2_q <= meta2_d;

      ay3_q   <= ay2_q;
      ax3_q   <= ax2_q;
      meta3_q <= meta2_q;
      cbl_q   <= cbl_d;

      ay4_q   <= ay3_q;
      ax4_q   <= ax3_q;
      meta4_q <= meta3_q;
      left4_q <= left4_d;
      amt4_q  <= amt4_d;

      out_q   <= out_d;
    end
  end

  assign valid_o = v5_q;
  assign data_o  = out_q;

endmodule

/* rtl/core/fca_step.sv */
module fca_step #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fca_pkg::cordic_t data_i,
  output logic             valid_o,
  output fca_pkg::cordic_t data_o
);
  import fca_pkg::*;

  localparam logic [DATA_W-1:0] ATAN = atan_turns(STEP);

  logic [DATA_W-1:0] dx, dy;
  cordic_t           data_d, data_q;
  logic              valid_q;

  assign dx = DATA_W'($signed(data_i.y) >>> STEP);
  assign dy = DATA_W'($signed(data_i.x) >>> STEP);

  always_comb begin
    data_d = data_i;
    // rotate toward the x axis
    if (!data_i.y[DATA_W-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ATAN;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/fca_back.sv */
module fca_back #(
  parameter int unsigned ANGLE_BITS = fca_pkg::DEF_ANGLE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  fca_pkg::cordic_t            data_i,
  output logic                        valid_o,
  output logic [fca_pkg::ANGLE_W-1:0] angle_o
);
  import fca_pkg::*;

  localparam int unsigned          SH      = Z_FRAC - ANGLE_BITS;
  localparam int unsigned          SUM_W   = NORM_TOP + 2;
  localparam logic [DATA_W-1:0]    Z_MAX   = DATA_W'(1) << NORM_TOP;
  localparam logic [SUM_W-1:0]     RND     = SUM_W'(1) << (SH - 1);
  localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                  v1_q, v2_q, v3_q;
  logic [NORM_TOP:0]     zc1_d, zc1_q;
  meta_t                 meta1_q, meta2_q;
  logic [SUM_W-1:0]      sum2;
  logic [ANGLE_BITS-1:0] th2_q;
  logic [ANGLE_BITS-1:0] ang;
  logic [ANGLE_W-1:0]    angle3_q;

  always_comb begin
    if (data_i.z[DATA_W-1]) begin
      zc1_d = '0;
    end else if (data_i.z > Z_MAX) begin
      zc1_d = Z_MAX[NORM_TOP:0];
    end else begin
      zc1_d = data_i.z[NORM_TOP:0];
    end
  end

  // round half up to the output angle grid
  assign sum2 = SUM_W'(zc1_q) + RND;

  always_comb begin
    case (meta2_q.kind)
      KIND_GENERAL: begin
        if (!meta2_q.yneg) begin
          ang = meta2_q.xneg ? (HALF - th2_q) : th2_q;
        end else begin
          ang = meta2_q.xneg ? (HALF + th2_q) : (ANGLE_BITS'(0) - th2_q);
        end
      end
      KIND_Y_ZERO: begin
        ang = meta2_q.xneg ? HALF : '0;
      end
      KIND_X_ZERO: begin
        ang = meta2_q.yneg ? (HALF + QUARTER) : QUARTER;
      end
      default: begin
        ang = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zc1_q    <= zc1_d;
      meta1_q  <= data_i.meta;
      th2_q    <= sum2[SUM_W-1:SH];
      meta2_q  <= meta1_q;
      angle3_q <= ANGLE_W'(ang);
    end
  end

  assign valid_o = v3_q;
  assign angle_o = angle3_q;

endmodule

/* rtl/core/full_circle_angle_unit.sv */
// channel  | direction | signals                             | contents
// ---------+-----------+-------------------------------------+---------------------------------
// s_axis   | in        | s_axis_tvalid/tready/tdata          | y_value, x_value
// m_axis   | out       | m_axis_tvalid/tready/tdata          | angle
// cfg      | in        | cfg_valid_i/cfg_ready_o/cfg_data_i  | zero_band
//
// one beat per cycle while the skid register is empty
// the path has 71 register stages: 5 front stages, 62 cordic stages, 3 back stages, output register
// reset clears all valid bits and sets zero_band to 1
// a stall on m_axis parks one result in a skid register, then holds the whole pipe
// s_axis_tready comes from a register, so it never depends on m_axis_tready
module full_circle_angle_unit #(
  parameter int unsigned INPUT_BITS = fca_pkg::DEF_INPUT_BITS,
  parameter int unsigned ANGLE_BITS = fca_pkg::DEF_ANGLE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // y_value, x_value
  input  logic [((2*INPUT_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // angle
  output logic [fca_pkg::ANGLE_W-1:0]           m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fca_pkg::BAND_W-1:0]            cfg_data_i
);
  import fca_pkg::*;

  logic [BAND_W-1:0]  band_q;
  logic               en;
  logic [STEPS:0]     stage_valid;
  cordic_t            stage_data [STEPS+1];
  logic               core_valid;
  logic [ANGLE_W-1:0] core_angle;
  logic               core_fire;
  logic               out_valid_q, skid_valid_q;
  logic [ANGLE_W-1:0] out_data_q, skid_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= BAND_RESET;
    end else if (cfg_valid_i) begin
      band_q <= cfg_data_i;
    end
  end

  // the pipe moves while the skid register is empty
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  fca_front #(
    .INPUT_BITS (INPUT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .band_i    (band_q),
    .valid_i   (s_axis_tvalid),
    .y_value_i (s_axis_tdata[INPUT_BITS-1:0]),
    .x_value_i (s_axis_tdata[2*INPUT_BITS-1:INPUT_BITS]),
    .valid_o   (stage_valid[0]),
    .data_o    (stage_data[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    fca_step #(
      .STEP (g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stage_valid[g]),
      .data_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  fca_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (stage_valid[STEPS]),
    .data_i  (stage_data[STEPS]),
    .valid_o (core_valid),
    .angle_o (core_angle)
  );

  assign core_fire = core_valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= core_fire;
      end
    end else if (core_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_data_q <= skid_valid_q ? skid_data_q : core_angle;
    end else if (core_fire) begin
      skid_data_q <= core_angle;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* test/tb_full_circle_angle_unit.sv */
`timescale 1ns / 100ps

module tb_full_circle_angle_unit;

  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned PIPE_CYCLES = 80;  // above the pipe latency
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef struct {
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] angle;
  } angle_case_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // y_value [31:0], x_value [63:32]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // angle [31:0]
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [fca_pkg::BAND_W-1:0] cfg_data_i = '0;

  logic [fca_pkg::BAND_W-1:0] zero_band_now = fca_pkg::BAND_RESET;
  logic [63:0] atan_q62 [fca_pkg::STEPS];
  angle_case_t pending_angles [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_request = 0;
  logic idle_on = 1'b1;

  full_circle_angle_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // arctangent of 2^-i in q62 turns
  task automatic build_atan_q62();
    logic [63:0] rad;
    logic [63:0] term;
    logic [127:0] prod;
    int unsigned e;
    atan_q62[0] = 64'd1 << 59;
    for (int i = 1; i < fca_pkg::STEPS; i++) begin
      rad = '0;
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        e = i * (2 * k + 1);
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) begin
          rad = rad - term;
        end else begin
          rad = rad + term;
        end
      end
      prod = {64'd0, rad} * {64'd0, fca_pkg::INV_TWO_PI_Q64};
      atan_q62[i] = prod[127:64];
    end
  endtask

  function automatic logic [63:0] first_quadrant_turns(logic [63:0] ax, logic [63:0] ay);
    logic [63:0] m;
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [63:0] z;
    int unsigned bl;
    m = (ax > ay) ? ax : ay;
    bl = 0;
    for (int b = 0; b < 64; b++) begin
      if (m[b]) bl = b + 1;
    end
    if (bl > 60) begin
      ax = ax >> (bl - 60);
      ay = ay >> (bl - 60);
    end else if (bl > 0) begin
      ax = ax << (60 - bl);
      ay = ay << (60 - bl);
    end
    cx = ax;
    cy = ay;
    z = '0;
    for (int i = 0; i < fca_pkg::STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (!cy[63]) begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + atan_q62[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - atan_q62[i];
      end
    end
    if (z[63]) begin
      z = '0;
    end else if (z > (64'd1 << 60)) begin
      z = 64'd1 << 60;
    end
    return (z + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [31:0] predict_angle(logic [31:0] yv, logic [31:0] xv);
    logic [31:0] ay;
    logic [31:0] ax;
    logic [31:0] th;
    ay = yv[31] ? -yv : yv;
    ax = xv[31] ? -xv : xv;
    if (ay < {1'b0, zero_band_now}) begin
      return xv[31] ? HALF_TURN : 32'd0;
    end
    if (ax < {1'b0, zero_band_now}) begin
      return yv[31] ? HALF_TURN + QUARTER_TURN : QUARTER_TURN;
    end
    th = 32'(first_quadrant_turns({32'd0, ax}, {32'd0, ay}));
    if (!yv[31]) begin
      return xv[31] ? HALF_TURN - th : th;
    end
    return xv[31] ? HALF_TURN + th : 32'd0 - th;
  endfunction

  task automatic send_pair(input logic [31:0] yv, input logic [31:0] xv);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {xv, yv};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_angles.push_back('{y: yv, x: xv, angle: predict_angle(yv, xv)});
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_zero_band(input logic [fca_pkg::BAND_W-1:0] band);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= band;
    do @(posedge clk_i); while (!cfg_ready_o);
    zero_band_now = band;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] random_component();
    int unsigned sel;
    logic [63:0] mag;
    logic [31:0] v;
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      v = $urandom;
    end else if (sel < 13) begin
      // magnitudes right around the zero band
      mag = {33'd0, zero_band_now};
      if ($urandom_range(0, 1) == 1) begin
        mag = mag + 64'($urandom_range(0, 2));
      end else if (mag >= 2) begin
        mag = mag - 64'($urandom_range(0, 2));
      end
      v = ($urandom_range(0, 1) == 1) ? -mag[31:0] : mag[31:0];
    end else if (sel < 15) begin
      case ($urandom_range(0, 4))
        0: v = VAL_MAX;
        1: v = VAL_MIN;
        2: v = 32'd0;
        3: v = 32'd1;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else begin
      v = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  task automatic test_axis_extremes();
    send_pair(0, 0);
    send_pair(0, -5);
    send_pair(5, 0);
    send_pair(-5, 0);
    send_pair(VAL_MAX, VAL_MAX);
    send_pair(VAL_MIN, VAL_MIN);
    send_pair(VAL_MIN, VAL_MAX);
    send_pair(VAL_MAX, VAL_MIN);
    send_pair(VAL_MIN, 0);
    send_pair(0, VAL_MIN);
    send_pair(1, 1);
    send_pair(-1, -1);
    send_pair(-1, VAL_MAX);  // tiny negative angle rounds to a full turn
    send_pair(1, VAL_MIN);
    send_pair(-1, VAL_MIN);
    send_pair(VAL_MAX, 1);
  endtask

  task automatic test_zero_band_edges();
    // no band at all: the origin takes the cordic path
    write_zero_band(31'd0);
    send_pair(0, 0);
    send_pair(0, -1);
    write_zero_band(31'd1000);
    send_pair(999, -3);
    send_pair(-1000, 999);
    send_pair(1000, 1000);
    send_pair(-999, -1000);
    write_zero_band(31'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFE, 5);
    send_pair(-32'sd2147483647, 32'h7FFF_FFFE);
    send_pair(VAL_MIN, VAL_MIN);
  endtask

  task automatic test_random_vectors();
    logic [fca_pkg::BAND_W-1:0] band;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: band = 31'd1;
        1: band = 31'($urandom_range(2, 4096));
        2: band = 31'($urandom_range(1, 32'h7FFF_FFFF));
        default: band = 31'd0;
      endcase
      write_zero_band(band);
      for (int n = 0; n < 400; n++) begin
        if (n % 50 == 0) idle_on = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
        send_pair(random_component(), random_component());
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    write_zero_band(31'd1);
    idle_on = 1'b0;
    hold_request = 400;
    for (int n = 0; n < 250; n++) begin
      send_pair($urandom, $urandom);
    end
    drain_results();
    idle_on = 1'b1;
  endtask

  // result sink: random stalls, long hold on request
  initial begin : angle_sink
    int unsigned wait_cycles;
    angle_case_t want;
    forever begin
      @(negedge clk_i);
      wait_cycles = idle_on ? $urandom_range(0, 10) : 0;
      if (hold_request != 0) begin
        wait_cycles = wait_cycles + hold_request;
        hold_request = 0;
      end
      if (wait_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected angle beat, actual %08h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_angles.pop_front();
        if (m_axis_tdata !== want.angle) begin
          $display("%0t: angle for y=%08h x=%08h expected %08h actual %08h",
                   $time, want.y, want.x, want.angle, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  initial begin
    build_atan_q62();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_axis_extremes();
    test_zero_band_edges();
    test_random_vectors();
    test_output_backpressure();
    drain_results();
    repeat (PIPE_CYCLES) @(posedge clk_i);
    if (pending_angles.size() != 0) begin
      $display("%0t: %0d angles never arrived", $time, pending_angles.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fca_pkg.sv
rtl/core/fca_front.sv
rtl/core/fca_step.sv
rtl/core/fca_back.sv
rtl/core/full_circle_angle_unit.sv
test/tb_full_circle_angle_unit.sv
